>>> hw/rtl/mbe_pkg.sv
package mbe_pkg;

  // Default number of bitmap bytes held in the store
  localparam int MAP_BYTES_DEF = 8;

  // Width of the in-use size and of the size register
  localparam int SIZE_W = 4;

  // Size register value after reset
  localparam logic [SIZE_W-1:0] CFG_RESET = 4'd8;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_SET   = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_TEST  = 3'd2,
    KIND_NEXT  = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_OR    = 3'd5
  } kind_t;

  // One result item
  typedef struct packed {
    logic        ok;
    logic [15:0] found_offset;
    logic [7:0]  data_byte;
  } rsp_t;

endpackage

>>> hw/rtl/mbe_if.sv
interface mbe_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] bit_offset;
  logic [2:0]  byte_index;
  logic [7:0]  operand_byte;

  modport source (output valid, kind, bit_offset, byte_index, operand_byte, input ready);
  modport sink (input valid, kind, bit_offset, byte_index, operand_byte, output ready);
endinterface

interface mbe_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] found_offset;
  logic [7:0]  data_byte;

  modport source (output valid, ok, found_offset, data_byte, input ready);
  modport sink (input valid, ok, found_offset, data_byte, output ready);
endinterface

interface mbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] bytes_in_use;

  modport source (output valid, bytes_in_use, input ready);
  modport sink (input valid, bytes_in_use, output ready);
endinterface

>>> hw/rtl/membership_bitmap_engine.sv
// Membership bitmap engine: a byte-organised bitmap of MAP_BYTES bytes held in
// a simple dual-port synchronous memory (one write, one read a cycle).
// Channels: req carries one request item (kind, bit_offset, byte_index,
// operand_byte); rsp returns exactly one result item per request (ok,
// found_offset, data_byte); cfg writes bytes_in_use, taken at any cycle and
// meant to change only while no request is in flight.
// Reset: rst is synchronous. After it the engine sweeps the memory to zero,
// one byte a cycle; req.ready stays low meanwhile.
// bytes_in_use returns to 8.
// Timing: a set, clear or or-byte request reads its byte, then writes it back
// in the next cycle; a test only reads it. Their result is registered in the
// access state and offered from the done state; the next request is taken
// only back in idle. A request that fails its bounds check goes straight to
// the done state. Find-next and is-empty walk the bytes through the memory
// read port at one byte a cycle, up to the in-use size.
// Stall: a finished result sits in the output register; the engine takes the
// next request while it waits and holds its own result until the register
// frees.
module membership_bitmap_engine import mbe_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mbe_cfg_if.sink   cfg,
  mbe_req_if.sink   req,
  mbe_rsp_if.source rsp
);

  // In-use size saturates at the store depth; the register is 4 bits wide
  localparam int CAP = (MAP_BYTES > 15) ? 15 : MAP_BYTES;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP);

  logic [SIZE_W-1:0] bytes_in_use;
  logic [SIZE_W-1:0] size;
  rsp_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid;
  rsp_t              out;

  // Size register: always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= CFG_RESET;
    end else if (cfg.valid) begin
      bytes_in_use <= cfg.bytes_in_use;
    end
  end

  assign size = (bytes_in_use > SIZE_CAP) ? SIZE_CAP : bytes_in_use;

  mbe_engine #(
    .MAP_BYTES (MAP_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .size      (size),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // Output register: load when empty or being drained this cycle
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.ok           = out.ok;
  assign rsp.found_offset = out.found_offset;
  assign rsp.data_byte    = out.data_byte;

endmodule

>>> hw/rtl/mbe_ram.sv
module mbe_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mbe_engine.sv
module mbe_engine import mbe_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mbe_req_if.sink           req,
  input  logic [SIZE_W-1:0] size,
  output rsp_t              res,
  output logic              res_valid,
  input  logic              res_ready
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  kind_t             op;
  logic [7:0]        operand_q;
  logic [7:0]        bitmask;
  logic [AW-1:0]     addr_q;
  logic [SIZE_W-1:0] ptr;
  logic [SIZE_W-1:0] chk_byte;
  logic              chk_first;
  logic [7:0]        first_mask;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;

  kind_t             kind_in;
  logic [15:0]       om1;
  logic [12:0]       byte_pos;
  logic              loc_ok;
  logic              next_ok;
  logic              or_ok;
  logic [SIZE_W-1:0] start_byte;
  logic [6:0]        limit;
  logic [7:0]        eff_mask;
  logic [7:0]        hit_bits;
  logic              hit;
  logic [2:0]        low_bit;

  function automatic logic [2:0] lowest_set(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  assign kind_in    = kind_t'(req.kind);
  assign om1        = req.bit_offset - 16'd1;
  assign byte_pos   = om1[15:3];
  assign loc_ok     = (req.bit_offset != 16'd0) && (byte_pos < {9'b0, size});
  assign limit      = {size, 3'b000};
  assign next_ok    = req.bit_offset < {9'b0, limit};
  assign start_byte = req.bit_offset[6:3];
  assign or_ok      = {1'b0, req.byte_index} < size;

  assign eff_mask = chk_first ? first_mask : 8'hFF;
  assign hit_bits = rdata & eff_mask;
  assign hit      = hit_bits != 8'h00;
  assign low_bit  = lowest_set(hit_bits);

  assign req.ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      ST_IDLE: begin
        priority case (kind_in)
          KIND_SET, KIND_CLEAR, KIND_TEST: begin
            re    = req.valid && loc_ok;
            raddr = AW'(byte_pos);
          end
          KIND_NEXT: begin
            re    = req.valid && next_ok;
            raddr = AW'(start_byte);
          end
          KIND_EMPTY: begin
            re    = req.valid && (size != '0);
            raddr = '0;
          end
          KIND_OR: begin
            re    = req.valid && or_ok;
            raddr = AW'(req.byte_index);
          end
          default: begin
            re = 1'b0;
          end
        endcase
      end
      ST_ACCESS: begin
        priority case (op)
          KIND_SET: begin
            we    = 1'b1;
            wdata = rdata | bitmask;
          end
          KIND_CLEAR: begin
            we    = 1'b1;
            wdata = rdata & ~bitmask;
          end
          KIND_OR: begin
            we    = 1'b1;
            wdata = rdata | operand_q;
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        re    = !hit && (ptr < size);
        raddr = AW'(ptr);
      end
      ST_DONE: begin
        re = 1'b0;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  mbe_ram #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            op               <= kind_in;
            operand_q        <= req.operand_byte;
            bitmask          <= 8'h01 << om1[2:0];
            addr_q           <= raddr;
            res.ok           <= 1'b0;
            res.found_offset <= req.bit_offset;
            res.data_byte    <= '0;
            state            <= ST_DONE;
            priority case (kind_in)
              KIND_SET, KIND_CLEAR, KIND_TEST: begin
                if (loc_ok) begin
                  state <= ST_ACCESS;
                end
              end
              KIND_OR: begin
                if (or_ok) begin
                  state <= ST_ACCESS;
                end
              end
              KIND_NEXT: begin
                if (next_ok) begin
                  ptr        <= start_byte + SIZE_W'(1);
                  chk_byte   <= start_byte;
                  chk_first  <= 1'b1;
                  first_mask <= 8'hFF << req.bit_offset[2:0];
                  state      <= ST_SCAN;
                end
              end
              KIND_EMPTY: begin
                if (size == '0) begin
                  res.ok <= 1'b1;
                end else begin
                  ptr        <= SIZE_W'(1);
                  chk_byte   <= '0;
                  chk_first  <= 1'b1;
                  first_mask <= 8'hFF;
                  state      <= ST_SCAN;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          // Read data of the addressed byte is now registered
          res.ok        <= (op == KIND_TEST) ? ((rdata & bitmask) != 8'h00) : 1'b1;
          res.data_byte <= (op == KIND_OR) ? (rdata | operand_q) : 8'h00;
          state         <= ST_DONE;
        end
        ST_SCAN: begin
          if (hit) begin
            res.ok <= (op == KIND_NEXT);
            if (op == KIND_NEXT) begin
              res.found_offset <= 16'({chk_byte, low_bit}) + 16'd1;
            end
            state <= ST_DONE;
          end else if (ptr >= size) begin
            res.ok <= (op == KIND_EMPTY);
            state  <= ST_DONE;
          end else begin
            ptr       <= ptr + SIZE_W'(1);
            chk_byte  <= ptr;
            chk_first <= 1'b0;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/mbe_checker.sv
module mbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [15:0] rsp_found_offset,
  input logic [7:0]  rsp_data_byte
);

  // Output register empties on reset
  a_rst_no_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
      && $stable(rsp_found_offset) && $stable(rsp_data_byte))
    else $error("stalled result changed");

  // One request in flight: ready drops after each acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  // A nonzero byte is only returned by a successful or-byte
  a_data_needs_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data_byte != 8'h00) |-> rsp_ok)
    else $error("data byte on a failed request");

endmodule

bind membership_bitmap_engine mbe_checker u_mbe_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_ok           (rsp.ok),
  .rsp_found_offset (rsp.found_offset),
  .rsp_data_byte    (rsp.data_byte)
);

>>> sim/mbe_result_checker.sv
module mbe_result_checker import mbe_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mbe_cfg_if          cfg,
  mbe_req_if          req,
  mbe_rsp_if          rsp,
  output int unsigned pending,
  output int unsigned mismatches,
  output int unsigned compared
);

  logic [7:0]        shadow_map [MAP_BYTES];
  logic [SIZE_W-1:0] shadow_bytes;
  rsp_t              awaited_results [$];
  rsp_t              seen;
  rsp_t              want;

  // Active bytes: the register saturates at the store size.
  function automatic int unsigned live_bytes();
    return (shadow_bytes > MAP_BYTES) ? MAP_BYTES : int'(shadow_bytes);
  endfunction

  // Map a 1-based bit offset to a byte and mask; 0 when out of range.
  function automatic logic bit_slot(input int unsigned offset, output int unsigned byte_pos,
                                    output logic [7:0] mask);
    if (offset == 0 || ((offset - 1) >> 3) >= live_bytes()) return 1'b0;
    byte_pos = (offset - 1) >> 3;
    mask     = 8'h01 << ((offset - 1) & 7);
    return 1'b1;
  endfunction

  // Apply one request to the shadow map and give the result it must produce.
  function automatic rsp_t apply_request(input logic [2:0] kind, input logic [15:0] offset,
                                         input logic [2:0] byte_idx, input logic [7:0] operand);
    rsp_t        res;
    int unsigned size_bits;
    int unsigned pos;
    int unsigned probe;
    logic [7:0]  mask;
    res.ok           = 1'b0;
    res.found_offset = offset;
    res.data_byte    = 8'h00;
    size_bits        = live_bytes() * 8;
    case (kind)
      KIND_SET: begin
        if (bit_slot(offset, pos, mask)) begin
          shadow_map[pos] |= mask;
          res.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (bit_slot(offset, pos, mask)) begin
          shadow_map[pos] &= ~mask;
          res.ok = 1'b1;
        end
      end
      KIND_TEST: begin
        if (bit_slot(offset, pos, mask) && (shadow_map[pos] & mask) != 8'h00) res.ok = 1'b1;
      end
      KIND_NEXT: begin
        if (offset <= size_bits) begin
          for (probe = offset + 1; probe <= size_bits; probe++) begin
            if (bit_slot(probe, pos, mask) && (shadow_map[pos] & mask) != 8'h00) begin
              res.ok           = 1'b1;
              res.found_offset = probe[15:0];
              break;
            end
          end
        end
      end
      KIND_EMPTY: begin
        res.ok = 1'b1;
        for (int i = 0; i < live_bytes(); i++) begin
          if (shadow_map[i] != 8'h00) res.ok = 1'b0;
        end
      end
      KIND_OR: begin
        if (byte_idx < live_bytes()) begin
          shadow_map[byte_idx] |= operand;
          res.data_byte = shadow_map[byte_idx];
          res.ok        = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = 8'h00;
      shadow_bytes = CFG_RESET;
      awaited_results.delete();
      mismatches = 0;
      compared   = 0;
      pending   <= 0;
    end else begin
      if (cfg.valid && cfg.ready) shadow_bytes = cfg.bytes_in_use;
      if (req.valid && req.ready)
        awaited_results.push_back(apply_request(req.kind, req.bit_offset, req.byte_index,
                                                req.operand_byte));
      if (rsp.valid && rsp.ready) begin
        seen = {rsp.ok, rsp.found_offset, rsp.data_byte};
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: ok=%0b found_offset=%0d data_byte=%02h",
                     seen.ok, seen.found_offset, seen.data_byte);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (seen.ok !== want.ok || seen.found_offset !== want.found_offset ||
              seen.data_byte !== want.data_byte) begin
            if (mismatches < 10)
              $display("mismatch (ok/offset/data): want %0b/%0d/%02h, got %0b/%0d/%02h",
                       want.ok, want.found_offset, want.data_byte,
                       seen.ok, seen.found_offset, seen.data_byte);
            mismatches++;
          end
        end
      end
      pending <= awaited_results.size();
    end
  end

endmodule

>>> sim/membership_bitmap_engine_tb.sv
module membership_bitmap_engine_tb;
  import mbe_pkg::*;

  localparam int MAP_BYTES        = MAP_BYTES_DEF;
  // Random items per map-size setting; eight settings give 1040 random items in all.
  localparam int RANDOM_PER_PHASE = 130;
  // Generous bound: every item at its longest gap, scan and response stall, several times over.
  localparam int CYCLE_LIMIT      = 200000;
  // One long response hold-off, taken once this many results have drained.
  localparam int HOLD_OFF_AT      = 300;
  localparam int HOLD_OFF_CYCLES  = 200;
  // Quiet time after the last result: a full scan plus the output register, with margin.
  localparam int DRAIN_CYCLES     = 2 * MAP_BYTES + 8;

  logic              clk;
  logic              rst;
  int unsigned       pending;
  int unsigned       mismatches;
  int unsigned       compared;
  int unsigned       sent          = 0;
  int unsigned       configs_seen  = 0;
  int unsigned       cycles        = 0;
  logic [SIZE_W-1:0] cur_bytes     = CFG_RESET;
  bit                quiet_send    = 1'b0;
  bit                quiet_take    = 1'b0;

  mbe_cfg_if cfg ();
  mbe_req_if req ();
  mbe_rsp_if rsp ();

  membership_bitmap_engine #(.MAP_BYTES(MAP_BYTES)) i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  // The checker watches all three channels, keeps its own copy of the map and
  // the size register, and hands back the outstanding count and the failures.
  mbe_result_checker #(.MAP_BYTES(MAP_BYTES)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (req),
    .rsp        (rsp),
    .pending    (pending),
    .mismatches (mismatches),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abandon the run if the engine stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request item: wait a random gap first (none during a quiet
  // stretch), then hold valid until the engine takes the item. Valid is left
  // high so that back-to-back items need no second assignment in one step.
  task automatic offer(input logic [2:0] kind, input logic [15:0] offset,
                       input logic [2:0] byte_idx, input logic [7:0] operand);
    int unsigned gap;
    if ($urandom_range(0, 59) == 0) quiet_send = !quiet_send;
    gap = quiet_send ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= kind;
    req.bit_offset   <= offset;
    req.byte_index   <= byte_idx;
    req.operand_byte <= operand;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  // Change the map size only once the engine is idle: drop valid, let every
  // awaited result come back, then write the register through its own channel.
  task automatic write_size(input logic [SIZE_W-1:0] value);
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg.valid        <= 1'b1;
    cfg.bytes_in_use <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_bytes = value;
    configs_seen++;
  endtask

  // Response side: stall a random number of cycles before each result, with
  // quiet stretches of none, and once a long hold-off so that the engine and
  // its output register fill up and the request side backs up.
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 59) == 0) quiet_take = !quiet_take;
      stall = quiet_take ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus: reset, a directed pass at the reset size, then random phases
  // across map sizes including zero, one, full and the saturating values.
  initial begin
    logic [SIZE_W-1:0] sizes [8];
    logic [2:0]        kind;
    logic [15:0]       offset;
    logic [2:0]        byte_idx;
    logic [7:0]        operand;
    int unsigned       live;
    int unsigned       pick;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.kind         <= KIND_SET;
    req.bit_offset   <= 16'd0;
    req.byte_index   <= 3'd0;
    req.operand_byte <= 8'h00;
    cfg.valid        <= 1'b0;
    cfg.bytes_in_use <= CFG_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset size of eight bytes (64 bits).
    offer(KIND_EMPTY, 16'd0,     3'd0, 8'h00);  // map is empty after reset
    offer(KIND_TEST,  16'd1,     3'd0, 8'h00);
    offer(KIND_SET,   16'd0,     3'd0, 8'h00);  // offset zero fails
    offer(KIND_SET,   16'd1,     3'd0, 8'h00);  // lowest bit
    offer(KIND_SET,   16'd64,    3'd0, 8'h00);  // highest in-use bit
    offer(KIND_SET,   16'd65,    3'd0, 8'h00);  // one past the in-use bits
    offer(KIND_SET,   16'hFFFF,  3'd0, 8'h00);  // largest offset
    offer(KIND_TEST,  16'd1,     3'd0, 8'h00);
    offer(KIND_TEST,  16'd64,    3'd0, 8'h00);
    offer(KIND_EMPTY, 16'd0,     3'd0, 8'h00);
    offer(KIND_NEXT,  16'd0,     3'd0, 8'h00);  // start of zero searches from bit one
    offer(KIND_NEXT,  16'd1,     3'd0, 8'h00);
    offer(KIND_NEXT,  16'd64,    3'd0, 8'h00);  // nothing above the top bit
    offer(KIND_NEXT,  16'd65,    3'd0, 8'h00);  // start beyond the in-use bits
    offer(KIND_NEXT,  16'hFFFF,  3'd0, 8'h00);
    offer(KIND_CLEAR, 16'd64,    3'd0, 8'h00);
    offer(KIND_CLEAR, 16'd64,    3'd0, 8'h00);  // clearing a clear bit still succeeds
    offer(KIND_CLEAR, 16'd0,     3'd0, 8'h00);
    offer(KIND_OR,    16'd0,     3'd7, 8'hA5);  // top byte
    offer(KIND_OR,    16'd0,     3'd0, 8'hFF);
    offer(KIND_OR,    16'd0,     3'd3, 8'h00);
    offer(KIND_NEXT,  16'd8,     3'd0, 8'h00);  // skips empty bytes up to the top one
    offer(3'd6,       16'hFFFF,  3'd7, 8'hFF);  // unused kinds leave the map alone
    offer(3'd7,       16'd5,     3'd2, 8'h3C);
    offer(KIND_EMPTY, 16'd0,     3'd0, 8'h00);

    sizes = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd9, 4'd6, 4'd8, 4'd8};
    sizes[6] = SIZE_W'($urandom_range(0, 15));

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      live = (cur_bytes > MAP_BYTES) ? MAP_BYTES : cur_bytes;
      repeat (RANDOM_PER_PHASE) begin
        // Weight towards sets so that searches and tests meet a populated map.
        pick = $urandom_range(0, 99);
        if (pick < 28)      kind = KIND_SET;
        else if (pick < 42) kind = KIND_CLEAR;
        else if (pick < 62) kind = KIND_TEST;
        else if (pick < 77) kind = KIND_NEXT;
        else if (pick < 84) kind = KIND_EMPTY;
        else if (pick < 95) kind = KIND_OR;
        else                kind = 3'($urandom_range(6, 7));
        // Keep most offsets inside the in-use bits and their edges; the rest anywhere.
        if ($urandom_range(0, 9) < 8) offset = 16'($urandom_range(0, live * 8 + 1));
        else                          offset = 16'($urandom_range(0, 16'hFFFF));
        if (live != 0 && $urandom_range(0, 9) < 8) byte_idx = 3'($urandom_range(0, live - 1));
        else                                       byte_idx = 3'($urandom_range(0, 7));
        // Mostly single-bit operands, so the map does not saturate too soon.
        if ($urandom_range(0, 3) == 0) operand = 8'($urandom_range(0, 255));
        else                           operand = 8'h01 << $urandom_range(0, 7);
        offer(kind, offset, byte_idx, operand);
      end
    end

    // Drain: drop valid, wait for every awaited result, then let the engine settle.
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent over %0d size settings (0 to 15), %0d results compared",
             sent, configs_seen, compared);
    $display("tb: random gaps on both channels, one %0d-cycle response hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
